// ----- src/qkd_pkg.sv -----
package qkd_pkg;

  localparam int LEVEL_COUNT = 6;
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS = 12;

  localparam int LEVEL_W = 3;
  localparam int KEY_W = 12;
  localparam int ENTRY_W = 10;

  localparam int QUAD_W = 4 * KEY_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_DEPTH = LEVEL_COUNT * TABLE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int LVL_IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] index;
    logic             is_new;
    logic             table_full;
  } res_t;

  function automatic logic [KEY_BITS-1:0] trim_key(input logic [KEY_W-1:0] key);
    logic [15:0] ext;
    ext = 16'(key);
    return ext[KEY_BITS-1:0];
  endfunction

  function automatic logic [QUAD_W-1:0] pack_quad(
    input logic [KEY_W-1:0] top_left,
    input logic [KEY_W-1:0] top_right,
    input logic [KEY_W-1:0] bottom_left,
    input logic [KEY_W-1:0] bottom_right
  );
    return {trim_key(top_left), trim_key(top_right),
            trim_key(bottom_left), trim_key(bottom_right)};
  endfunction

endpackage

// ----- src/qkd_in_if.sv -----
interface qkd_in_if;
  logic                        valid;
  logic                        ready;
  logic [qkd_pkg::LEVEL_W-1:0] level;
  logic [qkd_pkg::KEY_W-1:0]   key_top_left;
  logic [qkd_pkg::KEY_W-1:0]   key_top_right;
  logic [qkd_pkg::KEY_W-1:0]   key_bottom_left;
  logic [qkd_pkg::KEY_W-1:0]   key_bottom_right;

  modport source (
    output valid, level, key_top_left, key_top_right, key_bottom_left, key_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, level, key_top_left, key_top_right, key_bottom_left, key_bottom_right,
    output ready
  );
endinterface

// ----- src/qkd_out_if.sv -----
interface qkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [qkd_pkg::ENTRY_W-1:0] entry_index;
  logic                        is_new;
  logic                        table_full;

  modport source (
    output valid, entry_index, is_new, table_full,
    input  ready
  );

  modport sink (
    input  valid, entry_index, is_new, table_full,
    output ready
  );
endinterface

// ----- src/quad_key_dedup_table.sv -----
// Intern table for 2x2 quads of tile indices, one table per pyramid level.
// The input channel in_ch carries one quad per beat: a level and four keys.
// The result channel out_ch returns one beat per quad: the entry index, is_new
// when the quad was appended and table_full when a miss found no free entry.
// The block works on one quad at a time. A quad is accepted only while the
// block is idle; the stored entries of its level are then read one per cycle
// in insertion order through the single read port of the entry memory.
// A search ends at the first hit, or on a miss once all n entries of its level
// are read; an invalid level skips the search and returns table_full. The result
// is then loaded into the output register and the block goes back to idle.
// The result sits in an output register, so the next quad is accepted and
// searched while an earlier result still waits. If the receiver stalls with a
// result still held when the next search ends, the block waits until the
// held beat is taken.
// Reset clears the per-level counts at once; no clearing pass is needed since
// only entries below a level's count are ever read.
module quad_key_dedup_table (
  input  logic       clk,
  input  logic       rst_n,
  qkd_in_if.sink     in_ch,
  qkd_out_if.source  out_ch
);

  logic [qkd_pkg::QUAD_W-1:0] mem [qkd_pkg::MEM_DEPTH];
  logic [qkd_pkg::QUAD_W-1:0] rd_data_r;

  logic [qkd_pkg::CNT_W-1:0] cnt_r [qkd_pkg::LEVEL_COUNT];

  qkd_pkg::state_t state_r, state_nxt;
  logic [qkd_pkg::QUAD_W-1:0]  quad_r, quad_nxt;
  logic [qkd_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [qkd_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [qkd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [qkd_pkg::CNT_W-1:0]   rd_k_r, rd_k_nxt;
  logic                        pend_r, pend_nxt;
  logic [qkd_pkg::CNT_W-1:0]   pend_k_r, pend_k_nxt;
  qkd_pkg::res_t               res_r, res_nxt;

  logic                        out_valid_r;
  qkd_pkg::res_t               out_res_r;

  logic                        lvl_ok;
  logic                        match;
  logic                        rd_en;
  logic [qkd_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [qkd_pkg::ADDR_W-1:0]  wr_addr;
  logic                        cnt_inc;
  logic                        out_load;

  assign lvl_ok = {1'b0, in_ch.level} < 4'(qkd_pkg::LEVEL_COUNT);
  assign match  = rd_data_r == quad_r;

  always_comb begin
    state_nxt  = state_r;
    quad_nxt   = quad_r;
    level_nxt  = level_r;
    base_nxt   = base_r;
    count_nxt  = count_r;
    rd_k_nxt   = rd_k_r;
    pend_nxt   = 1'b0;
    pend_k_nxt = pend_k_r;
    res_nxt    = res_r;
    rd_en      = 1'b0;
    rd_addr    = base_r + qkd_pkg::ADDR_W'(rd_k_r);
    wr_en      = 1'b0;
    wr_addr    = base_r + qkd_pkg::ADDR_W'(count_r);
    cnt_inc    = 1'b0;
    out_load   = 1'b0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      qkd_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          quad_nxt  = qkd_pkg::pack_quad(in_ch.key_top_left, in_ch.key_top_right,
                                         in_ch.key_bottom_left, in_ch.key_bottom_right);
          level_nxt = in_ch.level;
          base_nxt  = qkd_pkg::ADDR_W'(in_ch.level) * qkd_pkg::ADDR_W'(qkd_pkg::TABLE_DEPTH);
          rd_k_nxt  = '0;
          if (lvl_ok) begin
            count_nxt = cnt_r[in_ch.level[qkd_pkg::LVL_IDX_W-1:0]];
            state_nxt = qkd_pkg::ST_SEARCH;
          end else begin
            res_nxt   = '{index: '0, is_new: 1'b0, table_full: 1'b1};
            state_nxt = qkd_pkg::ST_FINISH;
          end
        end
      end
      qkd_pkg::ST_SEARCH: begin
        if (pend_r && match) begin
          res_nxt   = '{index: pend_k_r, is_new: 1'b0, table_full: 1'b0};
          state_nxt = qkd_pkg::ST_FINISH;
        end else if (rd_k_r == count_r) begin
          if (count_r >= qkd_pkg::CNT_W'(qkd_pkg::TABLE_DEPTH)) begin
            res_nxt = '{index: '0, is_new: 1'b0, table_full: 1'b1};
          end else begin
            wr_en   = 1'b1;
            cnt_inc = 1'b1;
            res_nxt = '{index: count_r, is_new: 1'b1, table_full: 1'b0};
          end
          state_nxt = qkd_pkg::ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_k_nxt   = rd_k_r + 1'b1;
          pend_nxt   = 1'b1;
          pend_k_nxt = rd_k_r;
        end
      end
      qkd_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = qkd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qkd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qkd_pkg::ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quad_r   <= quad_nxt;
    level_r  <= level_nxt;
    base_r   <= base_nxt;
    count_r  <= count_nxt;
    rd_k_r   <= rd_k_nxt;
    pend_k_r <= pend_k_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= quad_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qkd_pkg::LEVEL_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_inc) begin
      cnt_r[level_r[qkd_pkg::LVL_IDX_W-1:0]] <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_index = qkd_pkg::ENTRY_W'(out_res_r.index);
  assign out_ch.is_new      = out_res_r.is_new;
  assign out_ch.table_full  = out_res_r.table_full;

`ifndef ASSERT_OFF
  a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_new && out_ch.table_full))
    else $error("Result beat marks a quad both new and full.");

  a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.table_full) |-> (out_ch.entry_index == '0))
    else $error("Full result beat carries a nonzero index.");

  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < qkd_pkg::CNT_W'(qkd_pkg::TABLE_DEPTH)))
    else $error("Entry written into a full level.");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qkd_pkg::ST_SEARCH)
      |-> (cnt_r[level_r[qkd_pkg::LVL_IDX_W-1:0]] <= qkd_pkg::CNT_W'(qkd_pkg::TABLE_DEPTH)))
    else $error("Level count exceeds the table depth.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != qkd_pkg::ST_IDLE))
    else $error("Accepted beat did not start a lookup.");
`endif

endmodule
